@@ sv/swept_circle_segment_hit_assert.svh @@
// Assertion macros for the swept circle hit test RTL.
`ifndef SWEPT_CIRCLE_SEGMENT_HIT_ASSERT_SVH
`define SWEPT_CIRCLE_SEGMENT_HIT_ASSERT_SVH

// same-cycle implication, checked on every rising clk_i outside reset
`define SCSH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCSH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/scsh_pkg.sv @@
// Types, constants and helpers for the swept circle segment hit test.
package scsh_pkg;

  localparam int COORD_W       = 32;
  localparam int RAD_W         = 21;
  localparam int REM_W         = 67;
  localparam int NUM_W         = 64;
  localparam int CNT_W         = 7;
  localparam int MAX_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROOT_STEPS    = 32;
  localparam int T_STEPS       = 32;

  typedef enum logic {
    U_DIV,
    U_SQRT
  } umode_e;

  typedef struct packed {
    logic             start;
    umode_e           mode;
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [REM_W-1:0] divisor;
    logic [CNT_W-1:0] count;
  } ureq_t;

  typedef struct packed {
    logic             busy;
    logic [NUM_W-1:0] q;
  } ursp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_VSET,
    ST_DX,
    ST_DY,
    ST_DSUM,
    ST_DSQ,
    ST_DRET,
    ST_STEP,
    ST_OX_M,
    ST_OX_D,
    ST_OX_W,
    ST_OY_M,
    ST_OY_D,
    ST_OY_W,
    ST_WX,
    ST_WY,
    ST_LX,
    ST_LY,
    ST_CMP,
    ST_TDIV,
    ST_TX,
    ST_TY,
    ST_TC
  } state_e;

  typedef enum logic [1:0] {
    PH_VTX,
    PH_LEN,
    PH_SEG
  } phase_e;

  // |a - b| for two signed coordinates; always fits 32 bits
  function automatic logic [COORD_W-1:0] diff_mag(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        n;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    n = -d;
    return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

  // base plus or minus an offset that keeps the result in range
  function automatic logic signed [COORD_W-1:0] apply_off(
      input logic signed [COORD_W-1:0] base, input logic neg, input logic [COORD_W-1:0] off);
    logic signed [COORD_W+1:0] b;
    logic signed [COORD_W+1:0] o;
    logic signed [COORD_W+1:0] r;
    b = {{2{base[COORD_W-1]}}, base};
    o = signed'({2'b00, off});
    r = neg ? (b - o) : (b + o);
    return r[COORD_W-1:0];
  endfunction

endpackage

@@ sv/scsh_iter.sv @@
// Shared iterative unit: restoring divide (one bit a cycle) or square root.
module scsh_iter import scsh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ureq_t req_i,
  output ursp_t rsp_o
);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  umode_e           mode_q;
  logic [REM_W-1:0] rem_q;
  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] q_q;
  logic [REM_W-1:0] div_q;

  logic [REM_W-1:0] r2;
  logic [REM_W-1:0] trial;
  logic             ge;

  always_comb begin
    if (mode_q == U_SQRT) begin
      r2    = {rem_q[REM_W-3:0], num_q[NUM_W-1 -: 2]};
      trial = {1'b0, q_q, 2'b01};
    end else begin
      r2    = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
      trial = div_q;
    end
    ge = (r2 >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.count;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      rem_q  <= req_i.rem;
      num_q  <= req_i.num;
      div_q  <= req_i.divisor;
      q_q    <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (r2 - trial) : r2;
      q_q   <= {q_q[NUM_W-2:0], ge};
      num_q <= (mode_q == U_SQRT) ? (num_q << 2) : (num_q << 1);
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.q    = q_q;

endmodule

@@ sv/swept_circle_segment_hit.sv @@
// Top level of the swept circle versus wall segment hit test.
//
//  channel  | signals                                        | dir
//  ---------+------------------------------------------------+-----
//  request  | start, seg_*_i, move_*_i; busy is out           | in
//  result   | done_o, hit_o, hit_at_vertex_o, distance_o,    | out
//           | samples_clipped_o                              |
//  config   | cfg_valid_i, cfg_hit_radius_i; cfg_ready_o out | in
//
// A request is taken when start is high and busy low; busy stays high until the
// result strobe done_o, which lasts one cycle and cannot be held off.
// A request computes the four vertex distances, the move length and the sample
// count (at most MAX_STEPS), then a distance per sample; a sample whose
// projection clamps to a segment end skips the projection divide. The run time
// is set by the shared divide/square-root unit, which retires one quotient bit
// or one root bit per cycle, and by the single 32x32 multiplier.
// Reset is asynchronous, active low; the radius returns to 0.25 units.
// The config port is always ready; write it only while busy is low.
`include "swept_circle_segment_hit_assert.svh"
module swept_circle_segment_hit import scsh_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] seg_start_x_i,
  input  logic signed [COORD_W-1:0] seg_start_y_i,
  input  logic signed [COORD_W-1:0] seg_end_x_i,
  input  logic signed [COORD_W-1:0] seg_end_y_i,
  input  logic signed [COORD_W-1:0] move_from_x_i,
  input  logic signed [COORD_W-1:0] move_from_y_i,
  input  logic signed [COORD_W-1:0] move_to_x_i,
  input  logic signed [COORD_W-1:0] move_to_y_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [RAD_W-1:0]          cfg_hit_radius_i,
  output logic                      done_o,
  output logic                      hit_o,
  output logic                      hit_at_vertex_o,
  output logic [COORD_W-1:0]        distance_o,
  output logic                      samples_clipped_o
);

  localparam int KW    = $clog2(MAX_STEPS + 1);
  localparam int OW    = COORD_W + KW;   // offset product width
  localparam int CW    = COORD_W + KW;   // step accumulator width
  localparam logic [RAD_W-1:0] RST_RAD = RAD_W'(1) << (FRAC_BITS - 2);

  state_e state_q, state_d;
  phase_e phase_q;

  logic [RAD_W-1:0] rad_q;

  // latched request
  logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q, fx_q, fy_q, tx_q, ty_q;

  // distance operands and result
  logic signed [COORD_W-1:0] pax_q, pay_q, pbx_q, pby_q;
  logic [COORD_W-1:0]        dres_q, min_q, len_q;
  logic [1:0]                vidx_q;

  // sample bookkeeping
  logic [KW-1:0] k_q, steps_q, i_q;
  logic [CW-1:0] kacc_q;
  logic          clip_q;
  logic signed [COORD_W-1:0] qx_q, qy_q, cx_q;
  logic [COORD_W-1:0]        t_q;

  // shared multiplier and accumulators
  logic [COORD_W-1:0]   mul_a, mul_b;
  logic [2*COORD_W-1:0] prod_q, acc_q, lsq_q;
  logic signed [65:0]   dot_q;

  // result
  logic               done_q, hit_q, vtx_q, oclip_q;
  logic [COORD_W-1:0] dist_q;

  ureq_t ureq;
  ursp_t ursp;

  scsh_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .rsp_o  (ursp)
  );

  // combinational helpers
  logic [2*COORD_W:0]   dsum;
  logic [2*COORD_W:0]   lsq_sum;
  logic [COORD_W-1:0]   mval;
  logic                 mhit, dhit;
  logic [COORD_W-1:0]   rad_ext;
  logic [CW-1:0]        divisor;
  logic                 negx, negy, dot_pos, dot_ge;
  logic signed [65:0]   term;
  logic signed [COORD_W-1:0] cy;
  logic                 last_i;

  always_comb begin
    rad_ext = COORD_W'(rad_q);
    divisor = (rad_q == '0) ? CW'(1) : CW'(rad_q);
    dsum    = {1'b0, acc_q} + {1'b0, prod_q};
    lsq_sum = {1'b0, lsq_q} + {1'b0, prod_q};
    mval    = (vidx_q == 2'd0 || dres_q < min_q) ? dres_q : min_q;
    mhit    = (mval <= rad_ext);
    dhit    = (dres_q <= rad_ext);
    negx    = (qx_q < sx_q) != (ex_q < sx_q);
    negy    = (qy_q < sy_q) != (ey_q < sy_q);
    term    = signed'({2'b00, prod_q});
    dot_pos = !dot_q[65] && (dot_q != '0);
    dot_ge  = (dot_q[64:0] >= lsq_sum);
    cy      = apply_off(sy_q, ey_q < sy_q, prod_q[2*COORD_W-1:COORD_W]);
    last_i  = ((i_q + KW'(1)) == steps_q);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_DX: begin
        mul_a = diff_mag(pax_q, pbx_q);
        mul_b = mul_a;
      end
      ST_DY: begin
        mul_a = diff_mag(pay_q, pby_q);
        mul_b = mul_a;
      end
      ST_OX_M: begin
        mul_a = diff_mag(tx_q, fx_q);
        mul_b = COORD_W'(i_q);
      end
      ST_OY_M: begin
        mul_a = diff_mag(ty_q, fy_q);
        mul_b = COORD_W'(i_q);
      end
      ST_WX: begin
        mul_a = diff_mag(qx_q, sx_q);
        mul_b = diff_mag(ex_q, sx_q);
      end
      ST_WY: begin
        mul_a = diff_mag(qy_q, sy_q);
        mul_b = diff_mag(ey_q, sy_q);
      end
      ST_LX: begin
        mul_a = diff_mag(ex_q, sx_q);
        mul_b = mul_a;
      end
      ST_LY: begin
        mul_a = diff_mag(ey_q, sy_q);
        mul_b = mul_a;
      end
      ST_TX: begin
        mul_a = diff_mag(ex_q, sx_q);
        mul_b = t_q;
      end
      ST_TY: begin
        mul_a = diff_mag(ey_q, sy_q);
        mul_b = t_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // next state and unit requests
  always_comb begin
    state_d      = state_q;
    ureq         = '0;
    ureq.mode    = U_DIV;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_VSET;
      ST_VSET: state_d = ST_DX;
      ST_DX:   state_d = ST_DY;
      ST_DY:   state_d = ST_DSUM;
      ST_DSUM: begin
        if (dsum[2*COORD_W]) begin
          state_d = ST_DRET;
        end else begin
          ureq.start = 1'b1;
          ureq.mode  = U_SQRT;
          ureq.num   = dsum[NUM_W-1:0];
          ureq.count = CNT_W'(ROOT_STEPS);
          state_d    = ST_DSQ;
        end
      end
      ST_DSQ: if (!ursp.busy) state_d = ST_DRET;
      ST_DRET: begin
        case (phase_q)
          PH_VTX: begin
            if (vidx_q != 2'd3) state_d = ST_VSET;
            else if (mhit) state_d = ST_IDLE;
            else state_d = ST_DX;
          end
          PH_LEN: state_d = ST_STEP;
          PH_SEG: begin
            if (dhit || last_i) state_d = ST_IDLE;
            else state_d = ST_OX_M;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_STEP: begin
        if (kacc_q >= CW'(len_q)) begin
          state_d = (k_q == '0) ? ST_IDLE : ST_OX_M;
        end else if (k_q == KW'(MAX_STEPS)) begin
          state_d = ST_OX_M;
        end
      end
      ST_OX_M: state_d = ST_OX_D;
      ST_OY_M: state_d = ST_OY_D;
      ST_OX_D, ST_OY_D: begin
        ureq.start   = 1'b1;
        ureq.num     = prod_q << (NUM_W - OW);
        ureq.divisor = REM_W'(steps_q);
        ureq.count   = CNT_W'(OW);
        state_d      = (state_q == ST_OX_D) ? ST_OX_W : ST_OY_W;
      end
      ST_OX_W: if (!ursp.busy) state_d = ST_OY_M;
      ST_OY_W: if (!ursp.busy) state_d = ST_WX;
      ST_WX:   state_d = ST_WY;
      ST_WY:   state_d = ST_LX;
      ST_LX:   state_d = ST_LY;
      ST_LY:   state_d = ST_CMP;
      ST_CMP: begin
        if (lsq_sum == '0 || !dot_pos || dot_ge) begin
          state_d = ST_DX;
        end else begin
          ureq.start   = 1'b1;
          ureq.rem     = REM_W'(dot_q[64:0]);
          ureq.divisor = REM_W'(lsq_sum);
          ureq.count   = CNT_W'(T_STEPS);
          state_d      = ST_TDIV;
        end
      end
      ST_TDIV: if (!ursp.busy) state_d = ST_TX;
      ST_TX:   state_d = ST_TY;
      ST_TY:   state_d = ST_TC;
      ST_TC:   state_d = ST_DX;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rad_q   <= RST_RAD;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) rad_q <= cfg_hit_radius_i;
      done_q <= (state_q != ST_IDLE) && (state_d == ST_IDLE);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: if (start) begin
        sx_q    <= seg_start_x_i;
        sy_q    <= seg_start_y_i;
        ex_q    <= seg_end_x_i;
        ey_q    <= seg_end_y_i;
        fx_q    <= move_from_x_i;
        fy_q    <= move_from_y_i;
        tx_q    <= move_to_x_i;
        ty_q    <= move_to_y_i;
        vidx_q  <= 2'd0;
        phase_q <= PH_VTX;
        clip_q  <= 1'b0;
      end
      ST_VSET: begin
        pax_q <= vidx_q[0] ? tx_q : fx_q;
        pay_q <= vidx_q[0] ? ty_q : fy_q;
        pbx_q <= vidx_q[1] ? ex_q : sx_q;
        pby_q <= vidx_q[1] ? ey_q : sy_q;
      end
      ST_DY:   acc_q <= prod_q;
      ST_DSUM: if (dsum[2*COORD_W]) dres_q <= '1;
      ST_DSQ:  if (!ursp.busy) dres_q <= ursp.q[COORD_W-1:0];
      ST_DRET: begin
        case (phase_q)
          PH_VTX: begin
            min_q  <= mval;
            vidx_q <= vidx_q + 2'd1;
            if (vidx_q == 2'd3) begin
              if (mhit) begin
                hit_q   <= 1'b1;
                vtx_q   <= 1'b1;
                dist_q  <= mval;
                oclip_q <= 1'b0;
              end else begin
                pax_q   <= fx_q;
                pay_q   <= fy_q;
                pbx_q   <= tx_q;
                pby_q   <= ty_q;
                phase_q <= PH_LEN;
              end
            end
          end
          PH_LEN: begin
            len_q   <= dres_q;
            k_q     <= '0;
            kacc_q  <= '0;
            phase_q <= PH_SEG;
          end
          PH_SEG: begin
            i_q <= i_q + KW'(1);
            if (dhit) begin
              hit_q   <= 1'b1;
              vtx_q   <= 1'b0;
              dist_q  <= dres_q;
              oclip_q <= clip_q;
            end else if (last_i) begin
              hit_q   <= 1'b0;
              vtx_q   <= 1'b0;
              dist_q  <= '0;
              oclip_q <= clip_q;
            end
          end
          default: min_q <= min_q;
        endcase
      end
      ST_STEP: begin
        i_q <= '0;
        if (kacc_q >= CW'(len_q)) begin
          steps_q <= k_q;
          if (k_q == '0) begin
            hit_q   <= 1'b0;
            vtx_q   <= 1'b0;
            dist_q  <= '0;
            oclip_q <= 1'b0;
          end
        end else if (k_q == KW'(MAX_STEPS)) begin
          steps_q <= k_q;
          clip_q  <= 1'b1;
        end else begin
          kacc_q <= kacc_q + divisor;
          k_q    <= k_q + KW'(1);
        end
      end
      ST_OX_W: if (!ursp.busy) qx_q <= apply_off(fx_q, tx_q < fx_q, ursp.q[COORD_W-1:0]);
      ST_OY_W: if (!ursp.busy) qy_q <= apply_off(fy_q, ty_q < fy_q, ursp.q[COORD_W-1:0]);
      ST_WY:   dot_q <= negx ? -term : term;
      ST_LX:   dot_q <= dot_q + (negy ? -term : term);
      ST_LY:   lsq_q <= prod_q;
      ST_CMP: begin
        pax_q <= qx_q;
        pay_q <= qy_q;
        pbx_q <= (lsq_sum != '0 && dot_pos && dot_ge) ? ex_q : sx_q;
        pby_q <= (lsq_sum != '0 && dot_pos && dot_ge) ? ey_q : sy_q;
      end
      ST_TDIV: if (!ursp.busy) t_q <= ursp.q[COORD_W-1:0];
      ST_TY:   cx_q <= apply_off(sx_q, ex_q < sx_q, prod_q[2*COORD_W-1:COORD_W]);
      ST_TC: begin
        pbx_q <= cx_q;
        pby_q <= cy;
      end
      default: acc_q <= acc_q;
    endcase
  end

  assign busy              = (state_q != ST_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign hit_at_vertex_o   = vtx_q;
  assign distance_o        = dist_q;
  assign samples_clipped_o = oclip_q;

  `SCSH_ASSERT_IMP(a_done_idle, done_q, state_q == ST_IDLE, "result strobe outside idle")
  `SCSH_ASSERT_NXT(a_start_busy, start && !busy, busy, "request taken but not busy")
  `SCSH_ASSERT_IMP(a_vtx_hit, done_q && vtx_q, hit_q && !oclip_q, "bad vertex hit result")
  `SCSH_ASSERT_IMP(a_miss_zero, done_q && !hit_q, dist_q == '0, "miss with nonzero distance")
  `SCSH_ASSERT_IMP(a_unit_idle, state_q == ST_IDLE, !ursp.busy, "shared unit busy while idle")

endmodule
